### hw/rtl/apa_pkg.sv
// apa_pkg: shared types, constants and the reset image of the occupancy tree
// for the address pool allocator; no dependencies
package apa_pkg;

  localparam int unsigned AddrBits  = 32;
  localparam int unsigned HostBits  = 8;
  localparam int unsigned NodeBits  = HostBits + 1;
  localparam int unsigned TreeDepth = 1 << NodeBits;

  typedef logic [NodeBits-1:0] node_t;
  typedef logic [HostBits-1:0] host_t;
  typedef logic [AddrBits-1:0] addr_t;

  localparam node_t NodeRoot    = node_t'(1);
  localparam node_t LeafBase    = node_t'(1 << HostBits);
  localparam host_t HostBcast   = '1;
  localparam host_t HostBcastM1 = HostBcast ^ host_t'(1);

  localparam logic KindAlloc = 1'b0;
  localparam logic KindFree  = 1'b1;

  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StTaken    = 3'd1;
  localparam logic [2:0] StIllegal  = 3'd2;
  localparam logic [2:0] StFull     = 3'd3;
  localparam logic [2:0] StNotAlloc = 3'd4;

  typedef struct packed {
    logic  kind;
    addr_t address;
  } req_t;

  typedef struct packed {
    addr_t      granted_address;
    logic [2:0] status;
  } rsp_t;

  // one read and one write port of the mark memory
  typedef struct packed {
    logic  we;
    node_t waddr;
    logic  wdata;
    node_t raddr;
  } mem_req_t;

  // marks after reset: network, broadcast and broadcast-minus-one leaves,
  // plus the parent of the last two, which is then full
  function automatic logic reset_mark(node_t idx);
    logic m;
    m = (idx == LeafBase) ||
        (idx == (LeafBase | node_t'(HostBcast))) ||
        (idx == (LeafBase | node_t'(HostBcastM1))) ||
        (idx == ((LeafBase | node_t'(HostBcast)) >> 1));
    return m;
  endfunction

endpackage

### hw/rtl/address_pool_allocator.sv
// address_pool_allocator: top level with the prefix register, the result
// register and the tree walker and mark memory; uses apa_pkg, apa_mark_ram,
// apa_walker
//
// usage:
// - in channel (in_valid_i / in_ready_o / in_req_i): one beat is one request,
//   kind 0 allocates (address is the wished-for host), kind 1 frees
// - out channel (out_valid_o / out_ready_i / out_rsp_o): one beat per request,
//   granted address and status, in request order
// - cfg_we_i/cfg_wdata_i: user writes subnet_prefix only while idle; unchecked
// - the occupancy tree lives in a one-bit memory of 2^(HOST_BITS+1) entries,
//   read one tree level per cycle through its single registered read port
// - allocate: walks down the tree to a free leaf and marks it, then back up
//   marking full subtrees, and hands the result to the result register; a
//   full pool ends the walk at the root
// - free: walks up from the leaf clearing marks; rejected addresses skip it
// - one request is in flight at a time; the next is taken as soon as the
//   result sits in the output register, even if out_ready_i is low
// - a stalled receiver holds the result register; a finished walk then waits
//   in its done state and no further request is taken
// - after reset a sweep of all 2^(HOST_BITS+1) entries (512) loads the reset
//   image; in_ready_o stays low meanwhile, the prefix register reads zero
module address_pool_allocator import apa_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  cfg_we_i,
  input  addr_t cfg_wdata_i,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  req_t  in_req_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output rsp_t  out_rsp_o
);

  addr_t    prefix_q;
  mem_req_t mem_req;
  logic     mark;
  logic     init_done;
  logic     res_valid;
  logic     res_ready;
  rsp_t     res;
  logic     out_valid_q;
  rsp_t     out_q;

  // subnet prefix; host bits are ignored where it is used
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_q <= '0;
    end else if (cfg_we_i) begin
      prefix_q <= cfg_wdata_i;
    end
  end

  apa_mark_ram u_mark_ram (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (mem_req),
    .rdata_o     (mark),
    .init_done_o (init_done)
  );

  apa_walker u_walker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .prefix_i    (prefix_q),
    .init_done_i (init_done),
    .mark_i      (mark),
    .mem_o       (mem_req),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // result register frees the walker unless it is full and the receiver stalls
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

### hw/rtl/apa_mark_ram.sv
// apa_mark_ram: one-bit occupancy memory, one write and one registered read
// per cycle, with a sweep after reset that loads the reset image; uses apa_pkg
module apa_mark_ram import apa_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mem_req_t req_i,
  output logic     rdata_o,
  output logic     init_done_o
);

  logic  mem_q [TreeDepth];
  logic  rdata_q;
  node_t sweep_q;
  logic  init_done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q     <= '0;
      init_done_q <= 1'b0;
    end else if (!init_done_q) begin
      sweep_q <= sweep_q + node_t'(1);
      if (sweep_q == '1) begin
        init_done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!init_done_q) begin
      mem_q[sweep_q] <= reset_mark(sweep_q);
    end else if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem_q[req_i.raddr];
  end

  assign rdata_o     = rdata_q;
  assign init_done_o = init_done_q;

endmodule

### hw/rtl/apa_walker.sv
// apa_walker: sequencer that walks the occupancy tree down for allocate and
// back up to mark full subtrees, or up from a leaf for free; uses apa_pkg
module apa_walker import apa_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  req_t     in_req_i,
  input  addr_t    prefix_i,
  input  logic     init_done_i,
  input  logic     mark_i,
  output mem_req_t mem_o,
  output logic     res_valid_o,
  input  logic     res_ready_i,
  output rsp_t     res_o
);

  typedef enum logic [2:0] {
    SIdle,
    SRoot,
    SDown,
    SUp,
    SFree,
    SDone
  } state_e;

  state_e     state_q, state_d;
  node_t      node_q, node_d;
  node_t      child_q, child_d;
  host_t      hshift_q, hshift_d;
  host_t      host_q, host_d;
  logic       turned_q, turned_d;
  logic       pref_q, pref_d;
  logic       kind_q, kind_d;
  logic       outside_q, outside_d;
  logic       first_q, first_d;
  logic [2:0] status_q, status_d;

  always_comb begin
    node_t nxt;
    node_t par;
    logic  bn;
    logic  in_pool;
    host_t h;

    state_d   = state_q;
    node_d    = node_q;
    child_d   = child_q;
    hshift_d  = hshift_q;
    host_d    = host_q;
    turned_d  = turned_q;
    pref_d    = pref_q;
    kind_d    = kind_q;
    outside_d = outside_q;
    first_d   = first_q;
    status_d  = status_q;
    mem_o     = '0;

    h       = in_req_i.address[HostBits-1:0];
    in_pool = (in_req_i.address[AddrBits-1:HostBits] == prefix_i[AddrBits-1:HostBits]);
    nxt     = '0;
    par     = '0;
    bn      = 1'b0;

    unique case (state_q)
      SIdle: begin
        if (in_valid_i && init_done_i) begin
          kind_d    = in_req_i.kind;
          outside_d = !in_pool;
          status_d  = StOk;
          turned_d  = 1'b0;
          pref_d    = 1'b0;
          host_d    = '0;
          first_d   = 1'b1;
          if (in_req_i.kind == KindAlloc) begin
            // out-of-pool requests search from host zero
            hshift_d    = in_pool ? h : '0;
            mem_o.raddr = NodeRoot;
            state_d     = SRoot;
          end else if (in_pool && (h == '0 || h == HostBcast || h == HostBcastM1)) begin
            status_d = StIllegal;
            state_d  = SDone;
          end else if (!in_pool) begin
            status_d = StNotAlloc;
            state_d  = SDone;
          end else begin
            node_d      = LeafBase | node_t'(h);
            mem_o.raddr = LeafBase | node_t'(h);
            state_d     = SFree;
          end
        end
      end

      SRoot: begin
        if (mark_i) begin
          status_d = StFull;
          state_d  = SDone;
        end else begin
          child_d     = {NodeRoot[NodeBits-2:0], hshift_q[HostBits-1]};
          mem_o.raddr = {NodeRoot[NodeBits-2:0], hshift_q[HostBits-1]};
          hshift_d    = hshift_q << 1;
          state_d     = SDown;
        end
      end

      SDown: begin
        if (mark_i) begin
          // full subtree: take the sibling, prefer the refused bit below
          nxt = child_q ^ node_t'(1);
          if (!turned_q) begin
            turned_d = 1'b1;
            pref_d   = child_q[0];
            status_d = StTaken;
          end
        end else begin
          nxt = child_q;
        end
        if (nxt[NodeBits-1]) begin
          mem_o.we    = 1'b1;
          mem_o.waddr = nxt;
          mem_o.wdata = 1'b1;
          mem_o.raddr = nxt ^ node_t'(1);
          node_d      = nxt;
          host_d      = nxt[HostBits-1:0];
          state_d     = SUp;
        end else begin
          bn          = turned_d ? pref_d : hshift_q[HostBits-1];
          child_d     = {nxt[NodeBits-2:0], bn};
          mem_o.raddr = {nxt[NodeBits-2:0], bn};
          hshift_d    = hshift_q << 1;
        end
      end

      SUp: begin
        par = node_q >> 1;
        if (mark_i) begin
          mem_o.we    = 1'b1;
          mem_o.waddr = par;
          mem_o.wdata = 1'b1;
          if (par == NodeRoot) begin
            state_d = SDone;
          end else begin
            mem_o.raddr = par ^ node_t'(1);
            node_d      = par;
          end
        end else begin
          state_d = SDone;
        end
      end

      SFree: begin
        par = node_q >> 1;
        if (mark_i) begin
          mem_o.we    = 1'b1;
          mem_o.waddr = node_q;
          mem_o.wdata = 1'b0;
          first_d     = 1'b0;
          if (par == '0) begin
            state_d = SDone;
          end else begin
            mem_o.raddr = par;
            node_d      = par;
          end
        end else begin
          status_d = first_q ? StNotAlloc : StOk;
          state_d  = SDone;
        end
      end

      SDone: begin
        if (res_ready_i) begin
          state_d = SIdle;
        end
      end

      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SIdle;
      node_q    <= '0;
      child_q   <= '0;
      hshift_q  <= '0;
      host_q    <= '0;
      turned_q  <= 1'b0;
      pref_q    <= 1'b0;
      kind_q    <= KindAlloc;
      outside_q <= 1'b0;
      first_q   <= 1'b0;
      status_q  <= StOk;
    end else begin
      state_q   <= state_d;
      node_q    <= node_d;
      child_q   <= child_d;
      hshift_q  <= hshift_d;
      host_q    <= host_d;
      turned_q  <= turned_d;
      pref_q    <= pref_d;
      kind_q    <= kind_d;
      outside_q <= outside_d;
      first_q   <= first_d;
      status_q  <= status_d;
    end
  end

  assign in_ready_o  = (state_q == SIdle) && init_done_i;
  assign res_valid_o = (state_q == SDone);

  always_comb begin
    res_o = '0;
    if (kind_q == KindAlloc) begin
      res_o.status = (outside_q && status_q != StFull) ? StIllegal : status_q;
      if (status_q != StFull) begin
        res_o.granted_address = {prefix_i[AddrBits-1:HostBits], host_q};
      end
    end else begin
      res_o.status = status_q;
    end
  end

endmodule
